// File: hdl/baro_pressure_temperature_compensation_top_defines.svh
// assertion macros for the barometric compensation block
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef BARO_PRESSURE_TEMPERATURE_COMPENSATION_TOP_DEFINES_SVH
`define BARO_PRESSURE_TEMPERATURE_COMPENSATION_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BPTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BPTC_ASSERT_IMP(lbl, ante, cons, msg)
`define BPTC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: hdl/bptc_pkg.sv
// shared types and constants of the barometric compensation pipeline
// no dependencies
package bptc_pkg;

  // field widths
  localparam int unsigned RawW    = 24;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned TempW   = 15;
  localparam int unsigned PresW   = 17;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumRegs = 6;

  localparam logic [CfgIdxW-1:0] CfgIdxLimit = CfgIdxW'(NumRegs);

  // temperature and pressure limits, 0.01 units
  localparam int TempRef = 2000;
  localparam int TempLow = -1500;
  localparam int TempMin = -4000;
  localparam int TempMax = 8500;
  localparam int PresMin = 1000;
  localparam int PresMax = 120000;

  // shift amounts of the compensation formulas
  localparam int unsigned ShRefTemp = 8;
  localparam int unsigned ShSlope   = 23;
  localparam int unsigned ShOffTc   = 7;
  localparam int unsigned ShSensTc  = 8;
  localparam int unsigned ShDtSq    = 31;
  localparam int unsigned ShPres1   = 21;
  localparam int unsigned ShPres2   = 15;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SENS        = 3'd0,
    REG_OFFSET      = 3'd1,
    REG_SENS_TC     = 3'd2,
    REG_OFFSET_TC   = 3'd3,
    REG_REF_TEMP    = 3'd4,
    REG_TEMP_SLOPE  = 3'd5
  } cfg_reg_e;

  // calibration words
  typedef struct packed {
    logic [CoefW-1:0] sens;
    logic [CoefW-1:0] offset;
    logic [CoefW-1:0] sens_tc;
    logic [CoefW-1:0] offset_tc;
    logic [CoefW-1:0] ref_temp;
    logic [CoefW-1:0] temp_slope;
  } coef_t;

  // first-order results
  typedef struct packed {
    logic [RawW-1:0]   d1;
    logic signed [18:0] temp1;
    logic signed [17:0] a;      // temp1 - 2000
    logic signed [18:0] b;      // temp1 + 1500
    logic [16:0]        t2;
    logic signed [35:0] off1;
    logic signed [34:0] sens1;
  } first_t;

  // second-order corrected values
  typedef struct packed {
    logic [RawW-1:0]    d1;
    logic signed [TempW-1:0] temp;
    logic               tclip;
    logic signed [39:0] off;
    logic signed [39:0] sens;
  } second_t;

  // result word
  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic [PresW-1:0]        pres;
    logic                    clip;
  } result_t;

endpackage

// File: hdl/baro_pressure_temperature_compensation_top.sv
// Barometric sensor compensation: takes one raw pressure/temperature word per
// cycle and returns temperature in 0.01 C and pressure in 0.01 mbar, both
// saturated to the operating range, with clipped set when either was limited.
// The block is a ten-stage pipeline: a new word can enter every cycle unless
// all stages are full and the output is stalled. The depth is set by the
// products with the temperature difference, the two squares of the second-order
// terms and the raw pressure times sensitivity product, which is split into two
// partial products over two stages. Each stage holds its word until the next
// stage has room, so empty stages are filled even while the output waits.
// Calibration words are to be written through the cfg port only while the
// pipeline is empty, which the block itself does not enforce; writes to an index
// beyond the sixth register are dropped.
// depends on bptc_pkg, bptc_first, bptc_second, bptc_press and the defines header
`include "baro_pressure_temperature_compensation_top_defines.svh"

module baro_pressure_temperature_compensation_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [bptc_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [bptc_pkg::CoefW-1:0]            cfg_data_i,
  // input words
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [bptc_pkg::RawW-1:0]             raw_pressure_i,
  input  logic [bptc_pkg::RawW-1:0]             raw_temperature_i,
  // result words
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [bptc_pkg::TempW-1:0]     temp_centideg_o,
  output logic [bptc_pkg::PresW-1:0]            pressure_centimbar_o,
  output logic                                  clipped_o
);

  bptc_pkg::coef_t    coef_d, coef_q;
  bptc_pkg::first_t   first_data;
  bptc_pkg::second_t  second_data;
  bptc_pkg::result_t  result;
  logic               first_valid, first_ready;
  logic               second_valid, second_ready;

  assign cfg_ready_o = 1'b1;

  // calibration register write
  always_comb begin
    coef_d = coef_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bptc_pkg::REG_SENS:       coef_d.sens       = cfg_data_i;
        bptc_pkg::REG_OFFSET:     coef_d.offset     = cfg_data_i;
        bptc_pkg::REG_SENS_TC:    coef_d.sens_tc    = cfg_data_i;
        bptc_pkg::REG_OFFSET_TC:  coef_d.offset_tc  = cfg_data_i;
        bptc_pkg::REG_REF_TEMP:   coef_d.ref_temp   = cfg_data_i;
        bptc_pkg::REG_TEMP_SLOPE: coef_d.temp_slope = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  // first-order stages
  bptc_first u_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coef_i  (coef_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .d1_i    (raw_pressure_i),
    .d2_i    (raw_temperature_i),
    .valid_o (first_valid),
    .ready_i (first_ready),
    .data_o  (first_data)
  );

  // second-order stages
  bptc_second u_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (first_valid),
    .ready_o (first_ready),
    .data_i  (first_data),
    .valid_o (second_valid),
    .ready_i (second_ready),
    .data_o  (second_data)
  );

  // pressure stages and output register
  bptc_press u_press (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (second_valid),
    .ready_o (second_ready),
    .data_i  (second_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (result)
  );

  assign temp_centideg_o      = result.temp;
  assign pressure_centimbar_o = result.pres;
  assign clipped_o            = result.clip;

  // a free output always lets a word in
  `BPTC_ASSERT_IMP(a_ready_chain, out_ready_i, in_ready_o, "input stalled with output free")
  // results stay inside the operating range
  `BPTC_ASSERT_IMP(a_temp_range, out_valid_o,
    (temp_centideg_o >= bptc_pkg::TempMin) && (temp_centideg_o <= bptc_pkg::TempMax),
    "temperature out of range")
  `BPTC_ASSERT_IMP(a_pres_range, out_valid_o,
    (pressure_centimbar_o >= bptc_pkg::PresMin) && (pressure_centimbar_o <= bptc_pkg::PresMax),
    "pressure out of range")
  // writes beyond the register list leave calibration untouched
  `BPTC_ASSERT_NXT(a_cfg_ignore, cfg_valid_i && (cfg_index_i >= bptc_pkg::CfgIdxLimit),
    $stable(coef_q), "calibration changed by invalid index")

endmodule

// File: hdl/bptc_first.sv
// first-order stages: temperature difference, products, offset and sensitivity
// depends on bptc_pkg
module bptc_first (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bptc_pkg::coef_t       coef_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [bptc_pkg::RawW-1:0] d1_i,
  input  logic [bptc_pkg::RawW-1:0] d2_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output bptc_pkg::first_t      data_o
);

  typedef struct packed {
    logic [bptc_pkg::RawW-1:0] d1;
    logic signed [24:0]        dt;
  } s1_t;

  typedef struct packed {
    logic [bptc_pkg::RawW-1:0] d1;
    logic signed [41:0]        mt;
    logic signed [41:0]        mo;
    logic signed [41:0]        ms;
    logic [47:0]               dd;
  } s2_t;

  s1_t               s1_d, s1_q;
  s2_t               s2_d, s2_q;
  bptc_pkg::first_t  s3_d, s3_q;
  logic [2:0]        vld_q;
  logic [2:0]        adv;
  logic signed [49:0] dd_w;
  logic signed [17:0] a_w;

  // a stage moves when empty or when the next one moves
  assign adv[2]  = ~vld_q[2] | ready_i;
  assign adv[1]  = ~vld_q[1] | adv[2];
  assign adv[0]  = ~vld_q[0] | adv[1];
  assign ready_o = adv[0];
  assign valid_o = vld_q[2];
  assign data_o  = s3_q;

  // temperature difference
  always_comb begin
    s1_d.d1 = d1_i;
    s1_d.dt = $signed({1'b0, d2_i}) - $signed({1'b0, coef_i.ref_temp, 8'b0});
  end

  // products with the temperature difference
  always_comb begin
    s2_d.d1 = s1_q.d1;
    s2_d.mt = s1_q.dt * $signed({1'b0, coef_i.temp_slope});
    s2_d.mo = s1_q.dt * $signed({1'b0, coef_i.offset_tc});
    s2_d.ms = s1_q.dt * $signed({1'b0, coef_i.sens_tc});
    dd_w    = s1_q.dt * s1_q.dt;
    s2_d.dd = dd_w[47:0];
  end

  // first-order temperature, offset and sensitivity
  always_comb begin
    a_w        = s2_q.mt[bptc_pkg::ShSlope+17:bptc_pkg::ShSlope];
    s3_d.d1    = s2_q.d1;
    s3_d.a     = a_w;
    s3_d.temp1 = $signed({a_w[17], a_w}) + 19'(bptc_pkg::TempRef);
    s3_d.b     = $signed({a_w[17], a_w}) + 19'(bptc_pkg::TempRef - bptc_pkg::TempLow);
    s3_d.t2    = s2_q.dd[47:bptc_pkg::ShDtSq];
    s3_d.off1  = $signed({4'b0, coef_i.offset, 16'b0})
               + $signed({s2_q.mo[41], s2_q.mo[41:bptc_pkg::ShOffTc]});
    s3_d.sens1 = $signed({4'b0, coef_i.sens, 15'b0})
               + $signed({s2_q.ms[41], s2_q.ms[41:bptc_pkg::ShSensTc]});
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (adv[0]) s1_q <= s1_d;
    if (adv[1]) s2_q <= s2_d;
    if (adv[2]) s3_q <= s3_d;
  end

endmodule

// File: hdl/bptc_second.sv
// second-order correction stages and temperature saturation
// depends on bptc_pkg
module bptc_second (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  bptc_pkg::first_t  data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output bptc_pkg::second_t data_o
);

  typedef struct packed {
    logic [bptc_pkg::RawW-1:0] d1;
    logic signed [18:0]        temp1;
    logic                      lt_ref;
    logic                      lt_low;
    logic [16:0]               t2;
    logic signed [35:0]        off1;
    logic signed [34:0]        sens1;
    logic [34:0]               sq;
    logic [34:0]               sq2;
  } s1_t;

  typedef struct packed {
    logic [bptc_pkg::RawW-1:0] d1;
    logic signed [19:0]        temp;
    logic signed [35:0]        off1;
    logic signed [34:0]        sens1;
    logic [37:0]               off2;
    logic [37:0]               sens2;
  } s2_t;

  s1_t                s1_d, s1_q;
  s2_t                s2_d, s2_q;
  bptc_pkg::second_t  s3_d, s3_q;
  logic [2:0]         vld_q;
  logic [2:0]         adv;
  logic signed [35:0] sq_w;
  logic signed [37:0] sq2_w;
  logic [36:0]        five_sq;
  logic [37:0]        seven_sq2;
  logic [37:0]        eleven_sq2;

  assign adv[2]  = ~vld_q[2] | ready_i;
  assign adv[1]  = ~vld_q[1] | adv[2];
  assign adv[0]  = ~vld_q[0] | adv[1];
  assign ready_o = adv[0];
  assign valid_o = vld_q[2];
  assign data_o  = s3_q;

  // squares of the distance to the two thresholds
  always_comb begin
    sq_w         = data_i.a * data_i.a;
    sq2_w        = data_i.b * data_i.b;
    s1_d.d1      = data_i.d1;
    s1_d.temp1   = data_i.temp1;
    s1_d.lt_ref  = data_i.a[17];
    s1_d.lt_low  = data_i.b[18];
    s1_d.t2      = data_i.t2;
    s1_d.off1    = data_i.off1;
    s1_d.sens1   = data_i.sens1;
    s1_d.sq      = sq_w[34:0];
    s1_d.sq2     = sq2_w[34:0];
  end

  // correction terms, only below the reference temperature
  always_comb begin
    five_sq    = {2'b0, s1_q.sq} + {s1_q.sq, 2'b0};
    seven_sq2  = {s1_q.sq2, 3'b0} - {3'b0, s1_q.sq2};
    eleven_sq2 = {s1_q.sq2, 3'b0} + {2'b0, s1_q.sq2, 1'b0} + {3'b0, s1_q.sq2};
    s2_d.d1    = s1_q.d1;
    s2_d.off1  = s1_q.off1;
    s2_d.sens1 = s1_q.sens1;
    s2_d.temp  = $signed({s1_q.temp1[18], s1_q.temp1});
    s2_d.off2  = '0;
    s2_d.sens2 = '0;
    if (s1_q.lt_ref) begin
      s2_d.temp  = $signed({s1_q.temp1[18], s1_q.temp1}) - $signed({3'b0, s1_q.t2});
      s2_d.off2  = {2'b0, five_sq[36:1]};
      s2_d.sens2 = {3'b0, five_sq[36:2]};
      // extra term below the low threshold
      if (s1_q.lt_low) begin
        s2_d.off2  = {2'b0, five_sq[36:1]} + seven_sq2;
        s2_d.sens2 = {3'b0, five_sq[36:2]} + {1'b0, eleven_sq2[37:1]};
      end
    end
  end

  // corrected offset and sensitivity, temperature saturation
  always_comb begin
    s3_d.d1    = s2_q.d1;
    s3_d.off   = $signed({{4{s2_q.off1[35]}}, s2_q.off1}) - $signed({2'b0, s2_q.off2});
    s3_d.sens  = $signed({{5{s2_q.sens1[34]}}, s2_q.sens1}) - $signed({2'b0, s2_q.sens2});
    s3_d.temp  = s2_q.temp[bptc_pkg::TempW-1:0];
    s3_d.tclip = 1'b0;
    if (s2_q.temp < 20'(bptc_pkg::TempMin)) begin
      s3_d.temp  = bptc_pkg::TempW'(bptc_pkg::TempMin);
      s3_d.tclip = 1'b1;
    end else if (s2_q.temp > 20'(bptc_pkg::TempMax)) begin
      s3_d.temp  = bptc_pkg::TempW'(bptc_pkg::TempMax);
      s3_d.tclip = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) s1_q <= s1_d;
    if (adv[1]) s2_q <= s2_d;
    if (adv[2]) s3_q <= s3_d;
  end

endmodule

// File: hdl/bptc_press.sv
// pressure stages: split product, scaling, saturation and output register
// depends on bptc_pkg
module bptc_press (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  bptc_pkg::second_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output bptc_pkg::result_t data_o
);

  typedef struct packed {
    logic signed [bptc_pkg::TempW-1:0] temp;
    logic                              tclip;
    logic signed [39:0]                off;
    logic signed [44:0]                p_hi;
    logic [43:0]                       p_lo;
  } s1_t;

  typedef struct packed {
    logic signed [bptc_pkg::TempW-1:0] temp;
    logic                              tclip;
    logic signed [39:0]                off;
    logic signed [63:0]                prod;
  } s2_t;

  typedef struct packed {
    logic signed [bptc_pkg::TempW-1:0] temp;
    logic                              tclip;
    logic signed [28:0]                p;
  } s3_t;

  s1_t                s1_d, s1_q;
  s2_t                s2_d, s2_q;
  s3_t                s3_d, s3_q;
  bptc_pkg::result_t  s4_d, s4_q;
  logic [3:0]         vld_q;
  logic [3:0]         adv;
  logic signed [19:0] sens_hi;
  logic signed [43:0] q_w;

  assign adv[3]  = ~vld_q[3] | ready_i;
  assign adv[2]  = ~vld_q[2] | adv[3];
  assign adv[1]  = ~vld_q[1] | adv[2];
  assign adv[0]  = ~vld_q[0] | adv[1];
  assign ready_o = adv[0];
  assign valid_o = vld_q[3];
  assign data_o  = s4_q;

  // raw pressure times sensitivity as two partial products
  always_comb begin
    sens_hi    = data_i.sens[39:20];
    s1_d.temp  = data_i.temp;
    s1_d.tclip = data_i.tclip;
    s1_d.off   = data_i.off;
    s1_d.p_hi  = $signed({1'b0, data_i.d1}) * sens_hi;
    s1_d.p_lo  = data_i.d1 * data_i.sens[19:0];
  end

  // partial product recombination
  always_comb begin
    s2_d.temp  = s1_q.temp;
    s2_d.tclip = s1_q.tclip;
    s2_d.off   = s1_q.off;
    s2_d.prod  = $signed({s1_q.p_hi[43:0], 20'b0}) + $signed({20'b0, s1_q.p_lo});
  end

  // scale and remove offset
  always_comb begin
    q_w        = $signed({s2_q.prod[63], s2_q.prod[63:bptc_pkg::ShPres1]})
               - $signed({{4{s2_q.off[39]}}, s2_q.off});
    s3_d.temp  = s2_q.temp;
    s3_d.tclip = s2_q.tclip;
    s3_d.p     = q_w[43:bptc_pkg::ShPres2];
  end

  // pressure saturation
  always_comb begin
    s4_d.temp = s3_q.temp;
    s4_d.pres = s3_q.p[bptc_pkg::PresW-1:0];
    s4_d.clip = s3_q.tclip;
    if (s3_q.p < 29'(bptc_pkg::PresMin)) begin
      s4_d.pres = bptc_pkg::PresW'(bptc_pkg::PresMin);
      s4_d.clip = 1'b1;
    end else if (s3_q.p > 29'(bptc_pkg::PresMax)) begin
      s4_d.pres = bptc_pkg::PresW'(bptc_pkg::PresMax);
      s4_d.clip = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
      if (adv[3]) vld_q[3] <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) s1_q <= s1_d;
    if (adv[1]) s2_q <= s2_d;
    if (adv[2]) s3_q <= s3_d;
    if (adv[3]) s4_q <= s4_d;
  end

endmodule

// File: test/tb_baro_pressure_temperature_compensation_top.sv
// testbench for baro_pressure_temperature_compensation_top: random and directed
// raw sample pairs, predicted results compared field by field at the output
// depends on bptc_pkg and the rtl of the compensation block
`timescale 1ns / 1ps

module tb_baro_pressure_temperature_compensation_top;

  typedef struct packed {
    logic [bptc_pkg::RawW-1:0] pres;
    logic [bptc_pkg::RawW-1:0] temp;
  } raw_word_t;

  localparam int TimeoutNs = 2_000_000;
  localparam int SettleCycles = 12;
  localparam logic [bptc_pkg::RawW-1:0] MaxRaw = '1;
  localparam logic [bptc_pkg::RawW-1:0] TypD1 = 24'd9085466;
  localparam logic [bptc_pkg::RawW-1:0] TypD2 = 24'd8569150;
  localparam logic [bptc_pkg::CfgIdxW-1:0] CfgIdxTop = '1;
  // sens, offset, sens_tc, offset_tc, ref_temp, temp_slope
  localparam bptc_pkg::coef_t TypicalCalib = {16'd40127, 16'd36924, 16'd23317,
                                              16'd23282, 16'd33464, 16'd28312};
  localparam bptc_pkg::coef_t SkewedCalib = {16'hFFFF, 16'h0000, 16'h0000,
                                             16'hFFFF, 16'h0000, 16'hFFFF};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bptc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [bptc_pkg::CoefW-1:0] cfg_data = '0;

  logic in_valid = 1'b0;
  logic in_ready;
  logic [bptc_pkg::RawW-1:0] raw_pressure = '0;
  logic [bptc_pkg::RawW-1:0] raw_temperature = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [bptc_pkg::TempW-1:0] temp_centideg;
  logic [bptc_pkg::PresW-1:0] pressure_centimbar;
  logic clipped;

  raw_word_t pending_words[$];
  bptc_pkg::result_t expected_results[$];
  bptc_pkg::coef_t calib_model = '0;
  raw_word_t next_word;
  bptc_pkg::result_t want;
  int unsigned send_gap_pct = 7;
  int unsigned recv_stall_pct = 46;
  int unsigned mismatch_count = 0;

  baro_pressure_temperature_compensation_top DUT (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .raw_pressure_i       (raw_pressure),
    .raw_temperature_i    (raw_temperature),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .temp_centideg_o      (temp_centideg),
    .pressure_centimbar_o (pressure_centimbar),
    .clipped_o            (clipped)
  );

  always #5 clk = ~clk;

  // second-order compensation of one sample pair, 64-bit signed throughout
  function automatic bptc_pkg::result_t compensate_sample(
      input logic [bptc_pkg::RawW-1:0] d1_raw,
      input logic [bptc_pkg::RawW-1:0] d2_raw,
      input bptc_pkg::coef_t c);
    longint d1, dt, temp, off, sens, t2, off2, sens2, a, b, sq, sq2, p;
    logic clip;
    bptc_pkg::result_t r;
    d1 = longint'(d1_raw);
    dt = longint'(d2_raw) - (longint'(c.ref_temp) << bptc_pkg::ShRefTemp);
    temp = bptc_pkg::TempRef + ((dt * longint'(c.temp_slope)) >>> bptc_pkg::ShSlope);
    off = (longint'(c.offset) << 16)
          + ((dt * longint'(c.offset_tc)) >>> bptc_pkg::ShOffTc);
    sens = (longint'(c.sens) << 15)
           + ((dt * longint'(c.sens_tc)) >>> bptc_pkg::ShSensTc);
    t2 = 0;
    off2 = 0;
    sens2 = 0;
    // cold correction, with an extra term when very cold
    if (temp < bptc_pkg::TempRef) begin
      a = temp - bptc_pkg::TempRef;
      sq = a * a;
      t2 = (dt * dt) >>> bptc_pkg::ShDtSq;
      off2 = (5 * sq) >>> 1;
      sens2 = (5 * sq) >>> 2;
      if (temp < bptc_pkg::TempLow) begin
        b = temp - bptc_pkg::TempLow;
        sq2 = b * b;
        off2 = off2 + 7 * sq2;
        sens2 = sens2 + ((11 * sq2) >>> 1);
      end
    end
    temp = temp - t2;
    off = off - off2;
    sens = sens - sens2;
    p = (((d1 * sens) >>> bptc_pkg::ShPres1) - off) >>> bptc_pkg::ShPres2;
    // saturate to the operating range
    clip = 1'b0;
    if (temp < bptc_pkg::TempMin) begin
      temp = bptc_pkg::TempMin;
      clip = 1'b1;
    end
    if (temp > bptc_pkg::TempMax) begin
      temp = bptc_pkg::TempMax;
      clip = 1'b1;
    end
    if (p < bptc_pkg::PresMin) begin
      p = bptc_pkg::PresMin;
      clip = 1'b1;
    end
    if (p > bptc_pkg::PresMax) begin
      p = bptc_pkg::PresMax;
      clip = 1'b1;
    end
    r.temp = bptc_pkg::TempW'(temp);
    r.pres = bptc_pkg::PresW'(p);
    r.clip = clip;
    return r;
  endfunction

  // mostly temperatures around the reference point, some raw noise and extremes
  function automatic raw_word_t random_word(input bptc_pkg::coef_t c);
    raw_word_t w;
    int unsigned kind;
    int unsigned span;
    longint centre;
    kind = $urandom_range(99);
    w.pres = bptc_pkg::RawW'($urandom);
    w.temp = bptc_pkg::RawW'($urandom);
    if (kind < 10) begin
      w.pres = $urandom_range(1) ? MaxRaw : '0;
      w.temp = $urandom_range(1) ? MaxRaw : '0;
    end else if (kind >= 30) begin
      span = 1 << $urandom_range(23, 4);
      centre = (longint'(c.ref_temp) << bptc_pkg::ShRefTemp) - longint'(span)
               + longint'($urandom_range(2 * span));
      if (centre < 0) centre = 0;
      if (centre > longint'(MaxRaw)) centre = longint'(MaxRaw);
      w.temp = bptc_pkg::RawW'(centre);
      if (kind >= 60) w.pres = bptc_pkg::RawW'($urandom_range(12_000_000, 4_000_000));
    end
    return w;
  endfunction

  // calibration register write, mirrored into the prediction copy
  task automatic write_coef(input logic [bptc_pkg::CfgIdxW-1:0] idx,
                            input logic [bptc_pkg::CoefW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      bptc_pkg::REG_SENS:       calib_model.sens = data;
      bptc_pkg::REG_OFFSET:     calib_model.offset = data;
      bptc_pkg::REG_SENS_TC:    calib_model.sens_tc = data;
      bptc_pkg::REG_OFFSET_TC:  calib_model.offset_tc = data;
      bptc_pkg::REG_REF_TEMP:   calib_model.ref_temp = data;
      bptc_pkg::REG_TEMP_SLOPE: calib_model.temp_slope = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_calib(input bptc_pkg::coef_t c);
    write_coef(bptc_pkg::REG_SENS, c.sens);
    write_coef(bptc_pkg::REG_OFFSET, c.offset);
    write_coef(bptc_pkg::REG_SENS_TC, c.sens_tc);
    write_coef(bptc_pkg::REG_OFFSET_TC, c.offset_tc);
    write_coef(bptc_pkg::REG_REF_TEMP, c.ref_temp);
    write_coef(bptc_pkg::REG_TEMP_SLOPE, c.temp_slope);
  endtask

  task automatic queue_word(input logic [bptc_pkg::RawW-1:0] d1,
                            input logic [bptc_pkg::RawW-1:0] d2);
    pending_words.push_back({d1, d2});
  endtask

  // returns at a falling edge once every word is sent and every result is in
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // random words, with the sender held off halfway until the pipeline empties
  task automatic run_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      pending_words.push_back(random_word(calib_model));
    end
    wait_drained();
  endtask

  // input word driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(compensate_sample(raw_pressure, raw_temperature,
                                                     calib_model));
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          next_word = pending_words.pop_front();
          in_valid <= 1'b1;
          raw_pressure <= next_word.pres;
          raw_temperature <= next_word.temp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result word monitor and checker
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no expectation pending");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (temp_centideg !== want.temp) begin
            $error("temp_centideg: expected %0d, actual %0d", want.temp, temp_centideg);
            mismatch_count++;
          end
          if (pressure_centimbar !== want.pres) begin
            $error("pressure_centimbar: expected %0d, actual %0d", want.pres,
                   pressure_centimbar);
            mismatch_count++;
          end
          if (clipped !== want.clip) begin
            $error("clipped: expected %0d, actual %0d", want.clip, clipped);
            mismatch_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // stimulus sequence
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // calibration still at reset: all zero
    queue_word('0, '0);
    queue_word(MaxRaw, MaxRaw);
    queue_word(TypD1, TypD2);
    wait_drained();

    // typical calibration, directed corners
    load_calib(TypicalCalib);
    queue_word(TypD1, TypD2);
    queue_word(TypD1, 24'd8566784);   // exactly 20.00 C
    queue_word(TypD1, 24'd8566783);   // just below 20.00 C
    queue_word(TypD1, 24'd8000000);   // cold
    queue_word(TypD1, 24'd7400000);   // below -15.00 C
    queue_word(TypD1, 24'd9500000);   // warm
    queue_word(TypD1, '0);            // far too cold
    queue_word(TypD1, MaxRaw);        // far too hot
    queue_word('0, TypD2);            // pressure below range
    queue_word(MaxRaw, TypD2);        // pressure above range
    queue_word(MaxRaw, '0);
    queue_word('0, MaxRaw);
    queue_word(24'hAAAAAA, 24'h555555);
    queue_word(24'h555555, 24'hAAAAAA);
    wait_drained();
    run_random(190);

    // all-ones calibration; writes past the last register are dropped
    load_calib('1);
    write_coef(bptc_pkg::CfgIdxLimit, bptc_pkg::CoefW'($urandom));
    write_coef(CfgIdxTop, bptc_pkg::CoefW'($urandom));
    queue_word('0, '0);
    queue_word(MaxRaw, MaxRaw);
    wait_drained();
    run_random(190);

    // sender stalls more than receiver
    send_gap_pct = 46;
    recv_stall_pct = 7;
    load_calib(bptc_pkg::coef_t'({$urandom, $urandom, $urandom}));
    run_random(190);
    load_calib(TypicalCalib ^ (bptc_pkg::coef_t'({$urandom, $urandom, $urandom})
                               & {6{16'h0FFF}}));
    run_random(190);

    // back to back, no idling on either side
    send_gap_pct = 0;
    recv_stall_pct = 0;
    load_calib(SkewedCalib);
    run_random(95);
    load_calib(TypicalCalib);
    run_random(95);

    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TimeoutNs);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
